// ===== design/positional_array_list_core_macros.svh =====
// assertion macros for the positional array list checker
// expects clk and rst_n in the scope where a macro is used
`ifndef POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pal_pkg.sv =====
// shared types and codes for the positional array list
// no dependencies
`timescale 1ns / 1ps

package pal_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_SORTED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SCAN,
    OP_SHIFT_UP,
    OP_SHIFT_DN
  } cell_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                  op;
    logic                      cmp_less;
    logic signed [WORD_W-1:0]  word;
  } cell_ctl_t;

endpackage

// ===== design/pal_in_if.sv =====
// command channel of the positional array list
// depends on nothing
`timescale 1ns / 1ps

interface pal_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;
  logic [4:0]         position;

  modport source(output valid, output cmd, output value, output position, input ready);
  modport sink(input valid, input cmd, input value, input position, output ready);
endinterface

// ===== design/pal_out_if.sv =====
// result channel of the positional array list
// depends on nothing
`timescale 1ns / 1ps

interface pal_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [3:0] found_index;
  logic [4:0] entries_used;

  modport source(output valid, output status, output found, output found_index,
                 output entries_used, input ready);
  modport sink(input valid, input status, input found, input found_index,
               input entries_used, output ready);
endinterface

// ===== design/pal_cell.sv =====
// one list slot: holds an entry and a match flag, talks to its two neighbors
// depends on pal_pkg
`timescale 1ns / 1ps

module pal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                             clk,
  input  pal_pkg::cell_ctl_t               ctl,
  input  logic [CW-1:0]                    slot,
  input  logic [CW-1:0]                    count,
  input  logic signed [pal_pkg::WORD_W-1:0] left_entry,
  input  logic signed [pal_pkg::WORD_W-1:0] right_entry,
  input  logic                             right_flag,
  output logic signed [pal_pkg::WORD_W-1:0] entry,
  output logic                             flag
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [pal_pkg::WORD_W-1:0] entry_r;
  logic                              flag_r;
  logic                              hit;

  always_comb begin
    if (ctl.cmp_less) begin
      hit = entry_r < ctl.word;
    end else begin
      hit = entry_r == ctl.word;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      pal_pkg::OP_LOAD: begin
        flag_r <= (MY_IDX < count) && hit;
      end
      pal_pkg::OP_SCAN: begin
        // flags march toward cell 0, one cell a cycle
        flag_r <= right_flag;
      end
      pal_pkg::OP_SHIFT_UP: begin
        if (MY_IDX == slot) begin
          entry_r <= ctl.word;
        end else if (MY_IDX > slot) begin
          entry_r <= left_entry;
        end
      end
      pal_pkg::OP_SHIFT_DN: begin
        if (MY_IDX >= slot) begin
          entry_r <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule

// ===== design/positional_array_list_core.sv =====
// Positional array list: CAPACITY signed 32-bit entries held in a row of cells.
// One item is in work at a time; in_ch.ready is low while an item is in work or
// its result waits untaken. Insert and delete at a position finish in the cycle
// the item is accepted. Locate and sorted insert load a compare flag into every
// cell on acceptance, then shift the flags toward cell 0 one cell per cycle while
// a counter tracks the index: locate stops at the first hit or the last entry,
// and on an empty list finishes on acceptance; sorted insert scans every entry,
// then places the word in its own state, and finishes on acceptance on an empty
// or full list. The flag chain through the cells sets the length of a scan.
// depends on pal_pkg, pal_in_if, pal_out_if, pal_cell
`timescale 1ns / 1ps

module positional_array_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [IW-1:0]                     scan_r, scan_nxt;
  logic [CW-1:0]                     slot_r, slot_nxt;
  pal_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic signed [pal_pkg::WORD_W-1:0] value_r, value_nxt;

  logic                              out_valid_r, out_valid_nxt;
  pal_pkg::status_t                  out_status_r, out_status_nxt;
  logic                              out_found_r, out_found_nxt;
  logic [IW-1:0]                     out_fidx_r, out_fidx_nxt;
  logic [CW-1:0]                     out_count_r, out_count_nxt;

  pal_pkg::cell_ctl_t                ctl;
  logic [CW-1:0]                     cell_slot;
  logic signed [pal_pkg::WORD_W-1:0] entry_w [CAPACITY];
  logic                              flag_w  [CAPACITY];

  logic                              in_fire;
  logic                              full;
  logic                              last;
  logic [PW-1:0]                     pos_ext;
  logic [PW-1:0]                     cnt_ext;
  pal_pkg::cmd_t                     in_cmd;

  logic                              rsp_en;
  pal_pkg::status_t                  rsp_status;
  logic                              rsp_found;
  logic [IW-1:0]                     rsp_idx;
  logic [CW-1:0]                     rsp_count;

  logic [31:0]                       fidx_wide;
  logic [31:0]                       count_wide;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_cmd      = pal_pkg::cmd_t'(in_ch.cmd);
  assign full        = count_r == CW'(CAPACITY);
  assign pos_ext     = PW'(in_ch.position);
  assign cnt_ext     = PW'(count_r);
  assign last        = (CW'(scan_r) + CW'(1)) == count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    slot_nxt      = slot_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_found_nxt = out_found_r;
    out_fidx_nxt  = out_fidx_r;
    out_count_nxt = out_count_r;

    ctl.op        = pal_pkg::OP_HOLD;
    ctl.cmp_less  = 1'b0;
    ctl.word      = in_ch.value;
    cell_slot     = CW'(in_ch.position);

    rsp_en     = 1'b0;
    rsp_status = pal_pkg::ST_OK;
    rsp_found  = 1'b0;
    rsp_idx    = '0;
    rsp_count  = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_cmd;
          value_nxt = in_ch.value;
          scan_nxt  = '0;
          slot_nxt  = '0;
          unique case (in_cmd)
            pal_pkg::CMD_INSERT: begin
              rsp_en = 1'b1;
              if (full) begin
                rsp_status = pal_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                rsp_status = pal_pkg::ST_BADPOS;
              end else begin
                ctl.op    = pal_pkg::OP_SHIFT_UP;
                count_nxt = count_r + CW'(1);
                rsp_count = count_nxt;
              end
            end
            pal_pkg::CMD_DELETE: begin
              rsp_en = 1'b1;
              if (pos_ext >= cnt_ext) begin
                rsp_status = pal_pkg::ST_BADPOS;
              end else begin
                ctl.op    = pal_pkg::OP_SHIFT_DN;
                count_nxt = count_r - CW'(1);
                rsp_count = count_nxt;
              end
            end
            pal_pkg::CMD_LOCATE: begin
              if (count_r == '0) begin
                rsp_en = 1'b1;
              end else begin
                ctl.op    = pal_pkg::OP_LOAD;
                state_nxt = S_SCAN;
              end
            end
            pal_pkg::CMD_SORTED: begin
              if (full) begin
                rsp_en     = 1'b1;
                rsp_status = pal_pkg::ST_FULL;
              end else if (count_r == '0) begin
                // empty list: the word lands in slot 0 at once
                rsp_en    = 1'b1;
                ctl.op    = pal_pkg::OP_SHIFT_UP;
                cell_slot = '0;
                count_nxt = count_r + CW'(1);
                rsp_count = count_nxt;
              end else begin
                ctl.op       = pal_pkg::OP_LOAD;
                ctl.cmp_less = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.op = pal_pkg::OP_SCAN;
        if (cmd_r == pal_pkg::CMD_SORTED) begin
          // remember one past the last smaller entry seen so far
          if (flag_w[0]) begin
            slot_nxt = CW'(scan_r) + CW'(1);
          end
          if (last) begin
            state_nxt = S_PLACE;
          end else begin
            scan_nxt = scan_r + IW'(1);
          end
        end else begin
          if (flag_w[0]) begin
            rsp_en    = 1'b1;
            rsp_found = 1'b1;
            rsp_idx   = scan_r;
            state_nxt = S_IDLE;
          end else if (last) begin
            rsp_en    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            scan_nxt = scan_r + IW'(1);
          end
        end
      end
      S_PLACE: begin
        ctl.op    = pal_pkg::OP_SHIFT_UP;
        ctl.word  = value_r;
        cell_slot = slot_r;
        count_nxt = count_r + CW'(1);
        rsp_en    = 1'b1;
        rsp_count = count_nxt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rsp_en) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = rsp_status;
      out_found_nxt  = rsp_found;
      out_fidx_nxt   = rsp_idx;
      out_count_nxt  = rsp_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    slot_r       <= slot_nxt;
    cmd_r        <= cmd_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_count_r  <= out_count_nxt;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [pal_pkg::WORD_W-1:0] left_w;
    logic signed [pal_pkg::WORD_W-1:0] right_w;
    logic                              rflag_w;

    if (k == 0) begin : g_first
      assign left_w = ctl.word;
    end else begin : g_mid_l
      assign left_w = entry_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      // past the top there is no entry: keep own value, feed a clear flag
      assign right_w = entry_w[k];
      assign rflag_w = 1'b0;
    end else begin : g_mid_r
      assign right_w = entry_w[k+1];
      assign rflag_w = flag_w[k+1];
    end

    pal_cell #(
      .IDX(k),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot       (cell_slot),
      .count      (count_r),
      .left_entry (left_w),
      .right_entry(right_w),
      .right_flag (rflag_w),
      .entry      (entry_w[k]),
      .flag       (flag_w[k])
    );
  end

  assign fidx_wide  = 32'(out_fidx_r);
  assign count_wide = 32'(out_count_r);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.found_index  = fidx_wide[3:0];
  assign out_ch.entries_used = count_wide[4:0];

endmodule

// ===== design/pal_checker.sv =====
// port-level checks on the positional array list result channel, and the bind
// depends on pal_pkg, positional_array_list_core, positional_array_list_core_macros.svh
`timescale 1ns / 1ps
`include "positional_array_list_core_macros.svh"

module pal_checker #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_found,
  input logic [3:0] out_found_index,
  input logic [4:0] out_entries_used
);

  `PAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result item dropped")

  `PAL_ASSERT_NOW(a_status_code, out_valid, out_status == pal_pkg::ST_OK || out_status == pal_pkg::ST_FULL || out_status == pal_pkg::ST_BADPOS, "undefined status code")

  `PAL_ASSERT_NOW(a_count_range, out_valid, (CAPACITY > 31) || (out_entries_used <= CAPACITY), "entry count above capacity")

  `PAL_ASSERT_NOW(a_found_in_list, out_valid && out_found, (out_status == pal_pkg::ST_OK) && ((CAPACITY > 16) || (out_found_index < out_entries_used)), "found index outside the list")

  `PAL_ASSERT_NOW(a_full_count, out_valid && (out_status == pal_pkg::ST_FULL), (CAPACITY > 31) || (out_entries_used == CAPACITY), "full status on a list with room")

endmodule

bind positional_array_list_core pal_checker #(
  .CAPACITY(CAPACITY)
) u_pal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_found_index (out_ch.found_index),
  .out_entries_used(out_ch.entries_used)
);
